### sv/depth_tested_text_cell_rasterizer_assert.svh
// Assertion macros used by the checker file.
`ifndef DEPTH_TESTED_TEXT_CELL_RASTERIZER_ASSERT_SVH
`define DEPTH_TESTED_TEXT_CELL_RASTERIZER_ASSERT_SVH
`define DTR_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### sv/dtr_pkg.sv
package dtr_pkg;
    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_PLOT   = 3'd1,
        CMD_LINE   = 3'd2,
        CMD_RECT   = 3'd3,
        CMD_CIRCLE = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SPAN_RD,
        ST_SPAN_WAIT,
        ST_SPAN_WR,
        ST_CIRC_SQ,
        ST_CIRC_TEST,
        ST_READ_WAIT,
        ST_READ_TAKE,
        ST_DONE
    } state_t;

    localparam logic [15:0] LINE_H_GLYPH = 16'h2500;
    localparam logic [15:0] LINE_V_GLYPH = 16'h2502;
    localparam logic [7:0]  CLEAR_DEPTH  = 8'h80;
    localparam int unsigned CFG_WIDTH_IDX  = 0;
    localparam int unsigned CFG_HEIGHT_IDX = 1;

    // One cell as it sits in memory.
    typedef struct packed {
        logic [15:0] glyph;
        logic [15:0] attr;
        logic [7:0]  depth;
    } cell_t;
endpackage

### sv/dtr_ram.sv
module dtr_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/dtr_sqmul.sv
// Shared squaring unit for the circle walk: one registered product per request.
module dtr_sqmul (
    input  logic        clk,
    input  logic [12:0] a,
    output logic [25:0] prod_reg
);
    always_ff @(posedge clk)
    begin
        prod_reg <= a * a;
    end
endmodule

### sv/depth_tested_text_cell_rasterizer.sv
// Channel | Direction | Handshake     | Payload
// in      | input     | valid / stall | command .. depth
// out     | output    | valid / stall | cell_glyph .. cells_written
// cfg     | input     | valid / ready | cfg_index, cfg_data
// Each cell touched passes through a memory read, a wait and a depth-tested write.
// A circle adds a squaring step and a compare step per half-width candidate.
// Clear sweeps every entry, one per cycle, 2**(clog2(MAX_COLUMNS)+clog2(MAX_ROWS))
// entries, 8192 at the defaults.
// The store's glyph, attributes and depth are zeroed by a full sweep after
// reset; in_stall stays high until it ends. One item at a time: in_stall is high
// while a command runs or its result waits.
module depth_tested_text_cell_rasterizer #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [14:0] pos_x,
    input  logic signed [14:0] pos_y,
    input  logic signed [14:0] end_x,
    input  logic signed [14:0] end_y,
    input  logic signed [14:0] rect_width,
    input  logic signed [14:0] rect_height,
    input  logic [11:0]        radius,
    input  logic [15:0]        glyph,
    input  logic [15:0]        attributes,
    input  logic signed [7:0]  depth,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        cell_glyph,
    output logic [15:0]        cell_attributes,
    output logic signed [7:0]  cell_depth,
    output logic [14:0]        cells_written,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int CELLS = 1 << AW;

    dtr_pkg::state_t state_reg, state_next;

    logic [7:0]  aw_reg;
    logic [6:0]  ah_reg;
    logic        init_reg;
    logic [AW:0] sweep_reg, sweep_next;

    logic [2:0]         cmd_reg, cmd_next;
    logic signed [16:0] x_reg, x_next, xhi_reg, xhi_next;
    logic signed [16:0] y_reg, y_next, ylo_reg, ylo_next, yhi_reg, yhi_next;
    logic signed [16:0] rx_reg, rx_next;
    logic [15:0] g_reg, g_next, a_reg, a_next;
    logic signed [7:0] z_reg, z_next;
    logic [14:0] n_reg, n_next;
    logic signed [16:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [12:0] dy_reg, dy_next, dx_reg, dx_next, r_reg, r_next;
    logic [25:0] r2_reg, r2_next, dy2_reg, dy2_next;
    logic        pass2_reg, pass2_next;   // second row (cy-dy) of a circle step
    logic        sqdy_reg, sqdy_next;     // squaring unit currently serves dy
    logic [15:0] og_reg, og_next, oa_reg, oa_next;
    logic [7:0]  oz_reg, oz_next;

    logic [12:0] mul_a;
    logic [25:0] mul_p;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    dtr_pkg::cell_t  wcell, rcell;

    logic signed [16:0] effw, effh;
    assign effw = (32'(aw_reg) > MAX_COLUMNS) ? 17'(MAX_COLUMNS) : 17'(aw_reg);
    assign effh = (32'(ah_reg) > MAX_ROWS) ? 17'(MAX_ROWS) : 17'(ah_reg);

    dtr_sqmul u_sq (.clk(clk), .a(mul_a), .prod_reg(mul_p));

    dtr_ram #(.WIDTH($bits(dtr_pkg::cell_t)), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcell),
        .raddr(raddr), .rdata(rcell)
    );

    assign raddr = {y_reg[RW-1:0], x_reg[CW-1:0]};

    assign cfg_ready = (state_reg == dtr_pkg::ST_IDLE) && !init_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg <= 8'd80;
            ah_reg <= 7'd25;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == 1'(dtr_pkg::CFG_WIDTH_IDX))
            begin
                aw_reg <= cfg_data;
            end
            else
            begin
                ah_reg <= cfg_data[6:0];
            end
        end
    end

    assign in_stall  = (state_reg != dtr_pkg::ST_IDLE) || init_reg;
    assign out_valid = (state_reg == dtr_pkg::ST_DONE);
    assign cell_glyph      = og_reg;
    assign cell_attributes = oa_reg;
    assign cell_depth      = oz_reg;
    assign cells_written   = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtr_pkg::ST_IDLE;
            init_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (init_reg && sweep_reg == (AW+1)'(CELLS - 1))
            begin
                init_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;   x_reg <= x_next;   xhi_reg <= xhi_next;
        y_reg <= y_next;       ylo_reg <= ylo_next; yhi_reg <= yhi_next;
        rx_reg <= rx_next;     g_reg <= g_next;   a_reg <= a_next;
        z_reg <= z_next;       n_reg <= n_next;   cx_reg <= cx_next;
        cy_reg <= cy_next;     dy_reg <= dy_next; dx_reg <= dx_next;
        r_reg <= r_next;       r2_reg <= r2_next; dy2_reg <= dy2_next;
        pass2_reg <= pass2_next; sqdy_reg <= sqdy_next;
        og_reg <= og_next;     oa_reg <= oa_next; oz_reg <= oz_next;
    end

    // Next-state logic: reset sweep, command decode, span walk, circle walk and read.
    // Spans [lo,hi) are clipped to the active area and loaded via the block's variables.
    always_comb
    begin
        logic signed [16:0] px, py, ex, ey, lo, hi, hx, hy, dxs, yrow;
        logic               span_ok;
        state_next = state_reg;
        sweep_next = sweep_reg;
        cmd_next = cmd_reg;  x_next = x_reg;  xhi_next = xhi_reg;
        y_next = y_reg;      ylo_next = ylo_reg; yhi_next = yhi_reg;
        rx_next = rx_reg;    g_next = g_reg;  a_next = a_reg;
        z_next = z_reg;      n_next = n_reg;  cx_next = cx_reg;
        cy_next = cy_reg;    dy_next = dy_reg; dx_next = dx_reg;
        r_next = r_reg;      r2_next = r2_reg; dy2_next = dy2_reg;
        pass2_next = pass2_reg; sqdy_next = sqdy_reg;
        og_next = og_reg;    oa_next = oa_reg; oz_next = oz_reg;
        we = 1'b0;
        waddr = {y_reg[RW-1:0], x_reg[CW-1:0]};
        wcell = '{glyph: g_reg, attr: a_reg, depth: z_reg};
        mul_a = sqdy_reg ? dy_reg : dx_reg;
        px = 17'(pos_x); py = 17'(pos_y); ex = 17'(end_x); ey = 17'(end_y);
        lo = '0; hi = '0; hx = '0; hy = '0; span_ok = 1'b0;
        dxs = 17'(dx_reg);
        yrow = pass2_reg ? cy_reg - 17'(dy_reg) : cy_reg + 17'(dy_reg);

        if (init_reg)
        begin
            we = 1'b1;
            waddr = sweep_reg[AW-1:0];
            wcell = '{glyph: 16'd0, attr: 16'd0, depth: 8'd0};
            sweep_next = (sweep_reg == (AW+1)'(CELLS - 1)) ? '0 : sweep_reg + 1'b1;
        end
        else
        begin
            case (state_reg)
                dtr_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_next = command;
                        g_next = glyph; a_next = attributes; z_next = depth;
                        n_next = '0; og_next = '0; oa_next = '0; oz_next = '0;
                        case (command)
                            dtr_pkg::CMD_CLEAR:
                            begin
                                sweep_next = '0;
                                state_next = dtr_pkg::ST_CLEAR;
                            end
                            dtr_pkg::CMD_PLOT, dtr_pkg::CMD_READ:
                            begin
                                x_next = px; y_next = py;
                                if (px >= 0 && py >= 0 && px < effw && py < effh)
                                begin
                                    xhi_next = px + 17'sd1; yhi_next = py + 17'sd1;
                                    ylo_next = py;
                                    rx_next = px;
                                    state_next = (command == dtr_pkg::CMD_READ) ?
                                        dtr_pkg::ST_READ_WAIT : dtr_pkg::ST_SPAN_RD;
                                end
                                else
                                begin
                                    state_next = dtr_pkg::ST_DONE;
                                end
                            end
                            dtr_pkg::CMD_LINE:
                            begin
                                state_next = dtr_pkg::ST_DONE;
                                if (py == ey && py >= 0)
                                begin
                                    lo = (px < ex) ? px : ex; hi = (px < ex) ? ex : px;
                                    if (lo < 0) lo = '0;
                                    if (hi > effw) hi = effw;
                                    if (glyph == '0) g_next = dtr_pkg::LINE_H_GLYPH;
                                    if (lo < hi && py < effh)
                                    begin
                                        x_next = lo; rx_next = lo; xhi_next = hi;
                                        y_next = py; ylo_next = py; yhi_next = py + 17'sd1;
                                        state_next = dtr_pkg::ST_SPAN_RD;
                                    end
                                end
                                else if (px == ex && px >= 0)
                                begin
                                    lo = (py < ey) ? py : ey; hi = (py < ey) ? ey : py;
                                    if (lo < 0) lo = '0;
                                    if (hi > effh) hi = effh;
                                    if (glyph == '0) g_next = dtr_pkg::LINE_V_GLYPH;
                                    if (lo < hi && px < effw)
                                    begin
                                        x_next = px; rx_next = px; xhi_next = px + 17'sd1;
                                        y_next = lo; ylo_next = lo; yhi_next = hi;
                                        state_next = dtr_pkg::ST_SPAN_RD;
                                    end
                                end
                            end
                            dtr_pkg::CMD_RECT:
                            begin
                                lo = (px < 0) ? 17'sd0 : px;
                                hx = px + 17'(rect_width);
                                if (hx > effw) hx = effw;
                                hi = (py < 0) ? 17'sd0 : py;
                                hy = py + 17'(rect_height);
                                if (hy > effh) hy = effh;
                                x_next = lo; rx_next = lo; xhi_next = hx;
                                y_next = hi; ylo_next = hi; yhi_next = hy;
                                state_next = (lo < hx && hi < hy) ?
                                    dtr_pkg::ST_SPAN_RD : dtr_pkg::ST_DONE;
                            end
                            dtr_pkg::CMD_CIRCLE:
                            begin
                                cx_next = px; cy_next = py;
                                r_next = 13'(radius); dy_next = '0; dx_next = 13'(radius);
                                pass2_next = 1'b0;
                                if (glyph == '0) g_next = dtr_pkg::LINE_H_GLYPH;
                                // First pass through the multiplier squares r itself.
                                sqdy_next = 1'b0;
                                r2_next = '1;
                                state_next = dtr_pkg::ST_CIRC_SQ;
                            end
                            default: state_next = dtr_pkg::ST_DONE;
                        endcase
                    end
                end
                dtr_pkg::ST_CLEAR:
                begin
                    we = 1'b1;
                    waddr = sweep_reg[AW-1:0];
                    wcell = '{glyph: g_reg, attr: a_reg, depth: dtr_pkg::CLEAR_DEPTH};
                    if (sweep_reg == (AW+1)'(CELLS - 1))
                    begin
                        sweep_next = '0;
                        state_next = dtr_pkg::ST_DONE;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
                dtr_pkg::ST_SPAN_RD:   state_next = dtr_pkg::ST_SPAN_WAIT;
                dtr_pkg::ST_SPAN_WAIT: state_next = dtr_pkg::ST_SPAN_WR;
                dtr_pkg::ST_SPAN_WR:
                begin
                    if (z_reg >= $signed(rcell.depth))
                    begin
                        we = 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                    if (x_reg + 17'sd1 < xhi_reg)
                    begin
                        x_next = x_reg + 17'sd1;
                        state_next = dtr_pkg::ST_SPAN_RD;
                    end
                    else if (y_reg + 17'sd1 < yhi_reg)
                    begin
                        x_next = rx_reg;
                        y_next = y_reg + 17'sd1;
                        state_next = dtr_pkg::ST_SPAN_RD;
                    end
                    else if (cmd_reg == dtr_pkg::CMD_CIRCLE)
                    begin
                        state_next = dtr_pkg::ST_CIRC_TEST;
                    end
                    else
                    begin
                        state_next = dtr_pkg::ST_DONE;
                    end
                end
                dtr_pkg::ST_CIRC_SQ:
                begin
                    // Multiplier registers the square requested by mul_a for the test state.
                    state_next = dtr_pkg::ST_CIRC_TEST;
                end
                dtr_pkg::ST_CIRC_TEST:
                begin
                    if (r2_reg == '1)
                    begin
                        // Square of r arrived; next square dy.
                        r2_next = mul_p;
                        sqdy_next = 1'b1;
                        state_next = dtr_pkg::ST_CIRC_SQ;
                    end
                    else if (sqdy_reg)
                    begin
                        dy2_next = mul_p;
                        sqdy_next = 1'b0;
                        pass2_next = 1'b0;
                        state_next = dtr_pkg::ST_CIRC_SQ;
                    end
                    else if (pass2_reg)
                    begin
                        // Both rows done for this dy: advance.
                        pass2_next = 1'b0;
                        if (dy_reg == r_reg)
                        begin
                            state_next = dtr_pkg::ST_DONE;
                        end
                        else
                        begin
                            dy_next = dy_reg + 1'b1;
                            sqdy_next = 1'b1;
                            state_next = dtr_pkg::ST_CIRC_SQ;
                        end
                    end
                    else if ({1'b0, mul_p} + {1'b0, dy2_reg} < {1'b0, r2_reg})
                    begin
                        // dx qualifies: draw row cy+dy, then cy-dy.
                        span_ok = 1'b1;
                    end
                    else if (dx_reg == '0)
                    begin
                        // No half-width for this dy or beyond.
                        state_next = dtr_pkg::ST_DONE;
                    end
                    else
                    begin
                        dx_next = dx_reg - 1'b1;
                        state_next = dtr_pkg::ST_CIRC_SQ;
                    end
                end
                dtr_pkg::ST_READ_WAIT: state_next = dtr_pkg::ST_READ_TAKE;
                dtr_pkg::ST_READ_TAKE:
                begin
                    og_next = rcell.glyph; oa_next = rcell.attr; oz_next = rcell.depth;
                    state_next = dtr_pkg::ST_DONE;
                end
                dtr_pkg::ST_DONE:
                begin
                    if (!out_stall)
                    begin
                        state_next = dtr_pkg::ST_IDLE;
                    end
                end
                default: state_next = dtr_pkg::ST_IDLE;
            endcase

            // Circle row dispatch; also re-entered after a span for the second row.
            if (state_reg == dtr_pkg::ST_SPAN_WR && state_next == dtr_pkg::ST_CIRC_TEST)
            begin
                // After the first row, draw the mirrored row with the same dx.
                if (!pass2_reg)
                begin
                    pass2_next = 1'b1;
                    span_ok = 1'b1;
                    yrow = cy_reg - 17'(dy_reg);
                end
                else
                begin
                    state_next = dtr_pkg::ST_CIRC_TEST;
                end
            end
            if (span_ok)
            begin
                lo = cx_reg - dxs; hi = cx_reg + dxs;
                if (lo < 0) lo = '0;
                if (hi > effw) hi = effw;
                state_next = dtr_pkg::ST_CIRC_TEST;
                if (state_reg == dtr_pkg::ST_CIRC_TEST)
                begin
                    pass2_next = 1'b0;
                end
                if (yrow >= 0 && yrow < effh && lo < hi)
                begin
                    x_next = lo; rx_next = lo; xhi_next = hi;
                    y_next = yrow; ylo_next = yrow; yhi_next = yrow + 17'sd1;
                    state_next = dtr_pkg::ST_SPAN_RD;
                end
                else if (state_reg == dtr_pkg::ST_CIRC_TEST)
                begin
                    // Row skipped; go straight to the mirrored row.
                    yrow = cy_reg - 17'(dy_reg);
                    pass2_next = 1'b1;
                    if (yrow >= 0 && yrow < effh && lo < hi)
                    begin
                        x_next = lo; rx_next = lo; xhi_next = hi;
                        y_next = yrow; ylo_next = yrow; yhi_next = yrow + 17'sd1;
                        state_next = dtr_pkg::ST_SPAN_RD;
                    end
                end
                else
                begin
                    pass2_next = 1'b1;
                end
            end
            if (ylo_next > yhi_next) yhi_next = ylo_next;
        end
    end
endmodule

### sv/dtr_checker.sv
`include "depth_tested_text_cell_rasterizer_assert.svh"
module dtr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [14:0] cells_written
);
    `DTR_ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(cells_written), "result changed while stalled")
    `DTR_ASSERT_NEVER(a_busy_no_take, clk, rst_n, out_valid && !in_stall, "input taken while result pending")
    `DTR_ASSERT_NEVER(a_cfg_busy, clk, rst_n, cfg_ready && in_stall, "config taken while busy")
    `DTR_ASSERT_IMPL(a_take_busy, clk, rst_n, in_valid && !in_stall |=> in_stall, "block not busy after accept")
endmodule

bind depth_tested_text_cell_rasterizer dtr_checker u_dtr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cells_written(cells_written)
);
